[src/bptc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg - shared types and constants for barometer compensation
// Coefficient bundle, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int COEF_W   = 16;
	localparam int CFG_IDX_W = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] IDX_SENS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_SENS_TC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_OFFSET_TC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_REF_TEMP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] IDX_TEMP_SENS = 3'd5;

	// Datapath widths
	localparam int RAW_W   = 24;
	localparam int DT_W    = 25;
	localparam int PROD_W  = 42;
	localparam int SQDT_W  = 50;
	localparam int TEMP_W  = 20;
	localparam int ACC_W   = 40;
	localparam int HALF_W  = 20;
	localparam int PPLO_W  = 44;
	localparam int PPHI_W  = 45;
	localparam int FULL_W  = 66;
	localparam int DIFF_W  = 48;
	localparam int PRES_W  = 32;

	localparam int TEMP_SHIFT  = 23;
	localparam int OFF_SHIFT   = 7;
	localparam int SENS_SHIFT  = 8;
	localparam int T2_SHIFT    = 31;
	localparam int PRESS_SHIFT = 21;
	localparam int PDIV_SHIFT  = 15;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;

	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] sens_tc;
		logic [COEF_W-1:0] offset_tc;
		logic [COEF_W-1:0] ref_temp;
		logic [COEF_W-1:0] temp_sens;
	} coef_t;

endpackage

[src/bptc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_cfg - calibration coefficient registers
// Decodes writes on the configuration channel into six 16-bit coefficients.
// ----------------------------------------------------------------------------
module bptc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bptc_pkg::COEF_W-1:0]     wr_data,
	output bptc_pkg::coef_t                 coef
);

	bptc_pkg::coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				bptc_pkg::IDX_SENS:      coef_q.sens      <= wr_data;
				bptc_pkg::IDX_OFFSET:    coef_q.offset    <= wr_data;
				bptc_pkg::IDX_SENS_TC:   coef_q.sens_tc   <= wr_data;
				bptc_pkg::IDX_OFFSET_TC: coef_q.offset_tc <= wr_data;
				bptc_pkg::IDX_REF_TEMP:  coef_q.ref_temp  <= wr_data;
				bptc_pkg::IDX_TEMP_SENS: coef_q.temp_sens <= wr_data;
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

[src/baro_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation - barometer temperature/pressure compensation
// Nine-stage pipeline with second-order low-temperature correction.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration coefficients through the cfg channel (index 0..5)
//   while no item is in flight; cfg_ready is always high.
//   Feed one item per cycle on s_axis: raw pressure and raw temperature.
//   Each item yields exactly one item on m_axis: temperature in 0.01 degC,
//   pressure in 0.01 mbar (saturated to 32 bits) and, on tuser, a flag that
//   is set when the low-temperature correction was applied.
// Output: m_axis_tvalid is the valid bit of the last stage register, which
//   holds the result until m_axis_tready takes it.
// Throughput: one item per cycle unless stalled; the stage count is set by the multiplier
//   stages (coefficient products, the square of the temperature offset and
//   the split 24 x 40 pressure product) and the wide pressure add chain.
// Stall: every stage holds its own valid bit and loads only when it is empty
//   or its successor moves, so empty stages fill up while m_axis_tready is
//   low; s_axis_tready falls only once the whole pipe is full and the output
//   is stalled. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits and coefficients to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bptc_pkg::COEF_W-1:0]     cfg_data,
	// input items
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [47:0]                     s_axis_tdata,  // [23:0] raw_pressure,
	                                                       // [47:24] raw_temperature
	// result items
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [55:0]                     m_axis_tdata,  // [19:0] temperature_centideg,
	                                                       // [51:20] pressure_centimbar,
	                                                       // [55:52] zero
	output logic [0:0]                      m_axis_tuser   // [0] low_temp_corrected
);

	localparam int NSTG = 9;

	localparam logic signed [bptc_pkg::PROD_W-1:0] TDIV_BIAS =
		bptc_pkg::PROD_W'((64'd1 << bptc_pkg::TEMP_SHIFT) - 64'd1);
	localparam logic signed [bptc_pkg::DIFF_W-1:0] PDIV_BIAS =
		bptc_pkg::DIFF_W'((64'd1 << bptc_pkg::PDIV_SHIFT) - 64'd1);
	localparam logic signed [bptc_pkg::DIFF_W-1:0] PRES_MAX =
		bptc_pkg::DIFF_W'(64'h7FFF_FFFF);
	localparam logic signed [bptc_pkg::DIFF_W-1:0] PRES_MIN =
		-bptc_pkg::DIFF_W'(64'h8000_0000);

	bptc_pkg::coef_t coef;

	bptc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its successor loads.
	// ------------------------------------------------------------------
	logic [NSTG:1] vld_q;
	logic [NSTG:1] ld;

	always_comb begin
		ld[NSTG] = ~vld_q[NSTG] | m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ld[k] = ~vld_q[k] | ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = ld[1];

	// ------------------------------------------------------------------
	// Stage 1: dT = raw_temperature - ref_temp * 2^8
	// ------------------------------------------------------------------
	logic        [bptc_pkg::RAW_W-1:0] rawp_s1;
	logic signed [bptc_pkg::DT_W-1:0]  dt_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			rawp_s1 <= s_axis_tdata[23:0];
			dt_s1   <= $signed({1'b0, s_axis_tdata[47:24]})
			         - $signed({1'b0, coef.ref_temp, 8'd0});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: coefficient products and dT squared
	// ------------------------------------------------------------------
	logic        [bptc_pkg::RAW_W-1:0]  rawp_s2;
	logic signed [bptc_pkg::PROD_W-1:0] prod_ts_s2;
	logic signed [bptc_pkg::PROD_W-1:0] prod_off_s2;
	logic signed [bptc_pkg::PROD_W-1:0] prod_sens_s2;
	logic signed [bptc_pkg::SQDT_W-1:0] prod_dd_s2;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			rawp_s2      <= rawp_s1;
			prod_ts_s2   <= dt_s1 * $signed({1'b0, coef.temp_sens});
			prod_off_s2  <= dt_s1 * $signed({1'b0, coef.offset_tc});
			prod_sens_s2 <= dt_s1 * $signed({1'b0, coef.sens_tc});
			prod_dd_s2   <= dt_s1 * dt_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: first-order TEMP, OFF, SENS and T2
	// ------------------------------------------------------------------
	logic signed [bptc_pkg::PROD_W-1:0] ts_biased;
	logic signed [bptc_pkg::PROD_W-1:0] ts_quot;

	always_comb begin
		// truncate toward zero: bias negative products before the shift
		ts_biased = prod_ts_s2 + (prod_ts_s2[bptc_pkg::PROD_W-1] ? TDIV_BIAS : '0);
		ts_quot   = ts_biased >>> bptc_pkg::TEMP_SHIFT;
	end

	logic        [bptc_pkg::RAW_W-1:0]  rawp_s3;
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s3;
	logic signed [bptc_pkg::TEMP_W-1:0] t2_s3;
	logic signed [bptc_pkg::ACC_W-1:0]  off_s3;
	logic signed [bptc_pkg::ACC_W-1:0]  sens_s3;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			rawp_s3 <= rawp_s2;
			temp_s3 <= bptc_pkg::TEMP_REF + bptc_pkg::TEMP_W'(ts_quot);
			t2_s3   <= bptc_pkg::TEMP_W'(prod_dd_s2 >>> bptc_pkg::T2_SHIFT);
			off_s3  <= $signed({8'd0, coef.offset, 16'd0})
			         + bptc_pkg::ACC_W'(prod_off_s2 >>> bptc_pkg::OFF_SHIFT);
			sens_s3 <= $signed({9'd0, coef.sens, 15'd0})
			         + bptc_pkg::ACC_W'(prod_sens_s2 >>> bptc_pkg::SENS_SHIFT);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: low-temperature test, square of (TEMP - 2000), final TEMP
	// ------------------------------------------------------------------
	logic                               low_c;
	logic signed [bptc_pkg::TEMP_W-1:0] dtemp_c;

	assign low_c   = temp_s3 < bptc_pkg::TEMP_REF;
	assign dtemp_c = temp_s3 - bptc_pkg::TEMP_REF;

	logic        [bptc_pkg::RAW_W-1:0]  rawp_s4;
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s4;
	logic                               low_s4;
	logic signed [bptc_pkg::ACC_W-1:0]  sq_s4;
	logic signed [bptc_pkg::ACC_W-1:0]  off_s4;
	logic signed [bptc_pkg::ACC_W-1:0]  sens_s4;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			rawp_s4 <= rawp_s3;
			temp_s4 <= low_c ? (temp_s3 - t2_s3) : temp_s3;
			low_s4  <= low_c;
			sq_s4   <= dtemp_c * dtemp_c;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: for low-temperature items, subtract OFF2 and SENS2
	// ------------------------------------------------------------------
	logic signed [bptc_pkg::ACC_W-1:0] five_sq;

	assign five_sq = sq_s4 + (sq_s4 <<< 2);

	logic        [bptc_pkg::RAW_W-1:0]  rawp_s5;
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s5;
	logic                               low_s5;
	logic signed [bptc_pkg::ACC_W-1:0]  off_s5;
	logic signed [bptc_pkg::ACC_W-1:0]  sens_s5;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			rawp_s5 <= rawp_s4;
			temp_s5 <= temp_s4;
			low_s5  <= low_s4;
			off_s5  <= low_s4 ? (off_s4 - (five_sq >>> 1)) : off_s4;
			sens_s5 <= low_s4 ? (sens_s4 - (five_sq >>> 2)) : sens_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: raw_pressure * SENS as two partial products
	// ------------------------------------------------------------------
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s6;
	logic                               low_s6;
	logic signed [bptc_pkg::ACC_W-1:0]  off_s6;
	logic        [bptc_pkg::PPLO_W-1:0] pplo_s6;
	logic signed [bptc_pkg::PPHI_W-1:0] pphi_s6;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			temp_s6 <= temp_s5;
			low_s6  <= low_s5;
			off_s6  <= off_s5;
			pplo_s6 <= rawp_s5 * sens_s5[bptc_pkg::HALF_W-1:0];
			pphi_s6 <= $signed({1'b0, rawp_s5})
			         * $signed(sens_s5[bptc_pkg::ACC_W-1:bptc_pkg::HALF_W]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: combine partial products
	// ------------------------------------------------------------------
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s7;
	logic                               low_s7;
	logic signed [bptc_pkg::ACC_W-1:0]  off_s7;
	logic signed [bptc_pkg::FULL_W-1:0] full_s7;

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			temp_s7 <= temp_s6;
			low_s7  <= low_s6;
			off_s7  <= off_s6;
			full_s7 <= (bptc_pkg::FULL_W'(pphi_s6) <<< bptc_pkg::HALF_W)
			         + $signed({22'd0, pplo_s6});
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: floor(raw_p * SENS / 2^21) - OFF
	// ------------------------------------------------------------------
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s8;
	logic                               low_s8;
	logic signed [bptc_pkg::DIFF_W-1:0] diff_s8;

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			temp_s8 <= temp_s7;
			low_s8  <= low_s7;
			diff_s8 <= bptc_pkg::DIFF_W'(full_s7 >>> bptc_pkg::PRESS_SHIFT)
			         - bptc_pkg::DIFF_W'(off_s7);
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: truncating divide by 2^15, saturate, output register
	// ------------------------------------------------------------------
	logic signed [bptc_pkg::DIFF_W-1:0] diff_biased;
	logic signed [bptc_pkg::DIFF_W-1:0] pres_quot;
	logic signed [bptc_pkg::PRES_W-1:0] pres_sat;

	always_comb begin
		diff_biased = diff_s8 + (diff_s8[bptc_pkg::DIFF_W-1] ? PDIV_BIAS : '0);
		pres_quot   = diff_biased >>> bptc_pkg::PDIV_SHIFT;
		if (pres_quot > PRES_MAX) begin
			pres_sat = PRES_MAX[bptc_pkg::PRES_W-1:0];
		end else if (pres_quot < PRES_MIN) begin
			pres_sat = PRES_MIN[bptc_pkg::PRES_W-1:0];
		end else begin
			pres_sat = pres_quot[bptc_pkg::PRES_W-1:0];
		end
	end

	logic signed [bptc_pkg::TEMP_W-1:0] temp_s9;
	logic                               low_s9;
	logic signed [bptc_pkg::PRES_W-1:0] pres_s9;

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			temp_s9 <= temp_s8;
			low_s9  <= low_s8;
			pres_s9 <= pres_sat;
		end
	end

	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = {4'd0, pres_s9, temp_s9};
	assign m_axis_tuser  = low_s9;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// the correction flag agrees with the sign of the final temperature offset
	a_low_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (low_s9 == (temp_s9 < bptc_pkg::TEMP_REF)))
		else $error("low_temp_corrected disagrees with temperature");

	// input back-pressure only when the output side is blocked
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while output is free");

	// a stalled full pipe keeps every stage occupied
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_axis_tready && !m_axis_tready) |=> (vld_q == $past(vld_q)))
		else $error("pipeline valid bits changed during a full stall");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for barometer pressure/temperature compensation
// Drives raw pressure/temperature pairs over the input stream and predicts
// every compensated reading in 64-bit integer math. Each result item is
// checked field by field against the oldest prediction. Calibration sets
// run from all-zero through typical values to all-ones and random draws,
// with random input bursts, random output stalls and one long output
// hold-off that backs the pipe up to its input.
// ----------------------------------------------------------------------------
module tb_top;
	import bptc_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int RESET_CYCLES = 12;
	// Longest legitimate quiet stretch is the output hold-off below;
	// take the limit well above it.
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int STALL_LIMIT     = 1000;
	// Nine pipe stages; keep running after the last result so a stray extra one is caught.
	localparam int DRAIN_CYCLES    = 27;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 108;
	localparam int PRESSURE_ITEMS  = 48;
	localparam int MAX_PRINTED     = 100;

	// Spare register indexes: writes there must leave the calibration alone
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	localparam logic [RAW_W-1:0] RAW_MAX  = 24'hFFFFFF;
	localparam logic [COEF_W-1:0] COEF_MAX = 16'hFFFF;

	// Compensation constants
	localparam longint CENTI_20C      = 2000;
	localparam longint TEMP_DIVISOR   = 64'sd8388608;
	localparam longint PRESS_DIVISOR  = 64'sd32768;
	localparam int     REF_SHIFT      = 8;
	localparam int     OFF_BASE_SHIFT = 16;
	localparam int     SENS_BASE_SHIFT = 15;
	localparam int     OFF_TC_SHIFT   = 7;
	localparam int     SENS_TC_SHIFT  = 8;
	localparam int     DT_SQ_SHIFT    = 31;
	localparam int     PROD_SHIFT     = 21;

	typedef struct {
		logic signed [TEMP_W-1:0] temperature_centideg;
		logic signed [PRES_W-1:0] pressure_centimbar;
		logic                     low_temp_corrected;
	} reading_t;

	typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;   // [23:0] raw_pressure, [47:24] raw_temperature
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [55:0]          m_axis_tdata;   // [19:0] temperature_centideg,
	                                      // [51:20] pressure_centimbar, [55:52] zero
	logic [0:0]           m_axis_tuser;   // [0] low_temp_corrected

	// Calibration as the block should hold it, updated on each accepted write
	coef_t    cal;
	reading_t expected_readings[$];
	int       mismatch_count = 0;

	// Sender burst control
	bit sender_gaps = 1'b1;
	int burst_left  = 0;

	// Receiver hold-off request, picked up by the receiver process
	int hold_request = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	baro_pressure_temp_compensation DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// ------------------------------------------------------------------
	// Prediction: first-order compensation, then the second-order
	// correction below 20.00 degC. Shifts of negative values floor (>>>);
	// the two divisions truncate toward zero, as SV '/' does.
	// ------------------------------------------------------------------
	function automatic reading_t compensate(logic [RAW_W-1:0] raw_p,
	                                        logic [RAW_W-1:0] raw_t, coef_t c);
		longint   dt, temp, off, sens, d, sq, p;
		reading_t r;
		dt   = longint'({40'd0, raw_t}) - (longint'({48'd0, c.ref_temp}) << REF_SHIFT);
		temp = CENTI_20C + (dt * longint'({48'd0, c.temp_sens})) / TEMP_DIVISOR;
		off  = (longint'({48'd0, c.offset}) << OFF_BASE_SHIFT)
		     + ((longint'({48'd0, c.offset_tc}) * dt) >>> OFF_TC_SHIFT);
		sens = (longint'({48'd0, c.sens}) << SENS_BASE_SHIFT)
		     + ((longint'({48'd0, c.sens_tc}) * dt) >>> SENS_TC_SHIFT);
		r.low_temp_corrected = (temp < CENTI_20C);
		if (r.low_temp_corrected) begin
			// offset from 20 degC is taken before T2 comes off
			d    = temp - CENTI_20C;
			sq   = d * d;
			temp = temp - ((dt * dt) >>> DT_SQ_SHIFT);
			off  = off - ((5 * sq) >>> 1);
			sens = sens - ((5 * sq) >>> 2);
		end
		p = (((longint'({40'd0, raw_p}) * sens) >>> PROD_SHIFT) - off) / PRESS_DIVISOR;
		// saturate to 32 bits
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		r.temperature_centideg = temp[TEMP_W-1:0];
		r.pressure_centimbar   = p[PRES_W-1:0];
		return r;
	endfunction

	// Print the first mismatches, count them all
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------
	// Configuration writes. Valid stays high across back-to-back writes;
	// drop it with release_cfg once the set is done.
	// ------------------------------------------------------------------
	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
	                          input logic [COEF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			IDX_SENS:      cal.sens      = value;
			IDX_OFFSET:    cal.offset    = value;
			IDX_SENS_TC:   cal.sens_tc   = value;
			IDX_OFFSET_TC: cal.offset_tc = value;
			IDX_REF_TEMP:  cal.ref_temp  = value;
			IDX_TEMP_SENS: cal.temp_sens = value;
			default: ;  // spare index: ignored by the block
		endcase
	endtask

	task automatic release_cfg();
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Input items. Valid is not dropped after acceptance: the caller either
	// sends the next item in the same step or calls stream_idle.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {raw_t, raw_p};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		expected_readings.push_back(compensate(raw_p, raw_t, cal));
	endtask

	task automatic stream_idle();
		s_axis_tvalid <= 1'b0;
	endtask

	// Every item yields one result, so an empty queue means an empty pipe
	task automatic wait_drained();
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// Stop the stream, let the pipe empty, then load a full calibration set
	task automatic load_calibration(input coef_t c, input bit spare_write);
		stream_idle();
		wait_drained();
		if (spare_write)
			write_coef($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO,
			           16'($urandom_range(0, COEF_MAX)));
		write_coef(IDX_REF_TEMP,  c.ref_temp);
		write_coef(IDX_SENS,      c.sens);
		write_coef(IDX_TEMP_SENS, c.temp_sens);
		write_coef(IDX_OFFSET,    c.offset);
		write_coef(IDX_OFFSET_TC, c.offset_tc);
		write_coef(IDX_SENS_TC,   c.sens_tc);
		release_cfg();
	endtask

	// ------------------------------------------------------------------
	// Random field draws
	// ------------------------------------------------------------------
	function automatic logic [COEF_W-1:0] draw_coefficient();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return COEF_MAX;
			default: return 16'($urandom_range(0, COEF_MAX));
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] draw_raw();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return RAW_MAX;
			default: return 24'($urandom());
		endcase
	endfunction

	// Raw temperature a random distance from the reference reading, so that
	// both sides of 20 degC can show up when the temperature sensitivity is large enough.
	function automatic logic [RAW_W-1:0] near_reference(logic [COEF_W-1:0] ref_temp);
		int base, span, delta, t;
		base  = {8'd0, ref_temp, 8'd0};
		span  = 1 << $urandom_range(0, 20);
		delta = int'($urandom_range(0, span));
		if ($urandom_range(0, 1))
			delta = -delta;
		t = base + delta;
		if (t < 0)
			t = 0;
		if (t > int'({8'd0, RAW_MAX}))
			t = int'({8'd0, RAW_MAX});
		return t[RAW_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Receiver: stall pattern changes mode on random segments; a hold-off
	// request overrides it and is counted down here.
	// ------------------------------------------------------------------
	initial begin : receiver
		int         hold_left;
		int         segment_left;
		sink_mode_t sink_mode;
		hold_left     = 0;
		segment_left  = 0;
		sink_mode     = SINK_FREE;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (segment_left == 0) begin
					sink_mode    = sink_mode_t'($urandom_range(0, 2));
					segment_left = $urandom_range(16, 96);
				end
				segment_left--;
				case (sink_mode)
					SINK_FREE:  m_axis_tready <= 1'b1;
					SINK_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: pop the oldest prediction for every accepted result
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("result item with no input item pending");
			end else begin
				want = expected_readings.pop_front();
				if ($signed(m_axis_tdata[19:0]) !== want.temperature_centideg)
					report_mismatch($sformatf("temperature_centideg got %0d want %0d",
						$signed(m_axis_tdata[19:0]), want.temperature_centideg));
				if ($signed(m_axis_tdata[51:20]) !== want.pressure_centimbar)
					report_mismatch($sformatf("pressure_centimbar got %0d want %0d",
						$signed(m_axis_tdata[51:20]), want.pressure_centimbar));
				if (m_axis_tuser[0] !== want.low_temp_corrected)
					report_mismatch($sformatf("low_temp_corrected got %b want %b",
						m_axis_tuser[0], want.low_temp_corrected));
				if (m_axis_tdata[55:52] !== 4'd0)
					report_mismatch($sformatf("tdata pad bits got %h want 0",
						m_axis_tdata[55:52]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run once nothing moves on any channel for too long
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			    || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset every coefficient is zero: writes to spare indexes must
	// not disturb that, and readings come out as 20.00 degC and zero pressure.
	task automatic test_reset_state();
		write_coef(IDX_SPARE_LO, COEF_MAX);
		write_coef(IDX_SPARE_HI, 16'hA5A5);
		release_cfg();
		send_item('0, '0);
		send_item(RAW_MAX, RAW_MAX);
		send_item(RAW_MAX, '0);
	endtask

	// Field extremes, the 20 degC boundary and deep cold
	task automatic test_directed_corners();
		coef_t       c;
		logic [23:0] at_ref;
		c = '{sens: 16'd40127, offset: 16'd36924, sens_tc: 16'd23317,
		      offset_tc: 16'd23282, ref_temp: 16'd33464, temp_sens: 16'd28312};
		load_calibration(c, 1'b0);
		at_ref = {c.ref_temp, 8'd0};
		send_item(24'd9085466, 24'd8569150);     // room temperature
		send_item(24'd9085466, at_ref);          // dT zero: exactly 20.00 degC
		// dT slightly negative: the quotient truncates to zero, no correction
		send_item(24'd9085466, at_ref - 24'd296);
		// one step further: 19.99 degC, correction applies
		send_item(24'd9085466, at_ref - 24'd297);
		send_item('0, 24'd6000000);              // negative floor shifts
		send_item(RAW_MAX, '0);                  // far below -15 degC, no third order
		send_item('0, RAW_MAX);
		send_item(RAW_MAX, RAW_MAX);

		// every coefficient at full scale
		c = '{sens: COEF_MAX, offset: COEF_MAX, sens_tc: COEF_MAX,
		      offset_tc: COEF_MAX, ref_temp: COEF_MAX, temp_sens: COEF_MAX};
		load_calibration(c, 1'b1);
		send_item('0, '0);
		send_item(RAW_MAX, '0);
		send_item(RAW_MAX, RAW_MAX);
		send_item('0, RAW_MAX);
		send_item(RAW_MAX, {c.ref_temp, 8'd0});

		// no base sensitivity or offset, strong cold correction: for the cold
		// items the corrected sensitivity goes negative and so does pressure
		c = '{sens: '0, offset: '0, sens_tc: COEF_MAX,
		      offset_tc: COEF_MAX, ref_temp: COEF_MAX, temp_sens: COEF_MAX};
		load_calibration(c, 1'b0);
		send_item(RAW_MAX, '0);
		send_item(RAW_MAX, 24'd8000000);
		send_item(RAW_MAX, RAW_MAX);
	endtask

	// Random calibrations, each followed by a batch of random pairs, half of
	// them near the reference so that the correction switches on and off
	task automatic test_random_calibrations();
		coef_t       c;
		logic [23:0] raw_p, raw_t;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			c.sens      = draw_coefficient();
			c.offset    = draw_coefficient();
			c.sens_tc   = draw_coefficient();
			c.offset_tc = draw_coefficient();
			c.ref_temp  = draw_coefficient();
			c.temp_sens = draw_coefficient();
			load_calibration(c, 1'($urandom_range(0, 1)));
			// some phases stream back to back
			sender_gaps = ($urandom_range(0, 2) != 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				raw_p = draw_raw();
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: raw_t = near_reference(cal.ref_temp);
					5:             raw_t = $urandom_range(0, 1) ? RAW_MAX : '0;
					default:       raw_t = 24'($urandom());
				endcase
				send_item(raw_p, raw_t);
			end
		end
	endtask

	// Hold the output off for a long stretch while items keep coming, so the
	// pipe fills and the input stalls; then release and let it drain.
	task automatic test_output_hold_off();
		sender_gaps  = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		for (int n = 0; n < PRESSURE_ITEMS; n++)
			send_item(draw_raw(), near_reference(cal.ref_temp));
		stream_idle();
		sender_gaps = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cal = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_corners();
		test_random_calibrations();
		test_output_hold_off();

		wait_drained();
		// any result past the last prediction is caught by the checker here
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_readings.size() != 0)
			report_mismatch("predictions left over at the end");
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
src/bptc_pkg.sv
src/bptc_cfg.sv
src/baro_pressure_temp_compensation.sv
bench/tb_top.sv
